FILE: hdl/tcfd_pkg.sv
// shared constants and types of the text and cobs frame demux
// no dependencies
package tcfd_pkg;

	localparam int DEPTH = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_RESET = 2'd1;
	localparam logic [1:0] KIND_BYTE = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        last;
		logic [31:0] stamp;
	} result_t;

endpackage

FILE: hdl/tcfd_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module tcfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/tcfd_outq.sv
// two-entry result queue between the sequencer and the result channel
// depends on tcfd_pkg
module tcfd_outq import tcfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  result_t push_item,
	output logic    space,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t head
);

	logic [1:0] cnt_q;
	result_t    head_q;
	result_t    tail_q;
	logic       pop;

	assign pop = result_valid && result_ready;
	assign space = (cnt_q != 2'd2);
	assign result_valid = (cnt_q != 2'd0);
	assign head = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push_valid, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push_valid, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= push_item;
				end else begin
					tail_q <= push_item;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= push_item;
				end else begin
					head_q <= tail_q;
					tail_q <= push_item;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/text_and_cobs_frame_demux.sv
// top level: text pass-through and cobs frame decoder with a walking sequencer
// depends on tcfd_pkg, tcfd_ram, tcfd_outq
// text byte or marker: result is queued and visible in the cycle after the item; a frame byte is stored
// closing zero: the stored frame is checked group by group, then each group's decoded bytes
// and any inserted zero are emitted; no item is taken meanwhile
// a full result queue stalls the walk; reset: text mode, fill zero, queue empty
module text_and_cobs_frame_demux import tcfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  byte_in,
	input  logic [31:0] time_ms,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data,
	output logic        last_of_frame,
	output logic [31:0] frame_time
);

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_ONE_ZERO,
		MODE_COLLECT,
		MODE_DISCARD
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_RD,
		ST_CHK_EVAL,
		ST_CHK_CNT,
		ST_EMPTY,
		ST_E_CODE_RD,
		ST_E_CODE,
		ST_E_BYTE_RD,
		ST_E_BYTE,
		ST_E_ZERO,
		ST_DONE
	} state_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  e_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  end_q;
	logic [7:0]        code_q;
	logic [31:0]       stamp_q;

	logic              accept;
	logic              space;
	logic              push_valid;
	result_t           push_item;
	result_t           head;
	logic              wr_en;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic [SUM_W-1:0]  alu_a;
	logic [SUM_W-1:0]  alu_b;
	logic              alu_dec;
	logic [SUM_W-1:0]  alu_sum;
	logic              is_last;

	assign byte_ready = (state_q == ST_IDLE) && space;
	assign accept = byte_valid && byte_ready;
	assign is_last = ((e_q + CNT_W'(1)) == n_q);

	// shared adder: group end during check and emit, decoded length during check
	always_comb begin
		alu_a = SUM_W'(idx_q);
		alu_b = SUM_W'(rd_data);
		alu_dec = 1'b0;
		if (state_q == ST_CHK_CNT) begin
			alu_a = SUM_W'(n_q);
			alu_b = SUM_W'(code_q);
			alu_dec = !((code_q != 8'hFF) && (idx_q < fill_q));
		end
	end

	assign alu_sum = alu_a + alu_b - SUM_W'(alu_dec);

	always_comb begin
		wr_en = accept && (mode_q == MODE_COLLECT) && (byte_in != 8'd0)
			&& (fill_q < CNT_W'(DEPTH));
		rd_en = 1'b0;
		rd_addr = idx_q[ADDR_W-1:0];
		case (state_q)
			ST_CHK_RD: rd_en = (idx_q < fill_q);
			ST_E_CODE_RD: rd_en = 1'b1;
			ST_E_BYTE_RD: begin
				rd_en = (pos_q != end_q);
				rd_addr = pos_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push_valid = 1'b0;
		push_item = '{kind: KIND_TEXT, data: byte_in, last: 1'b0, stamp: 32'd0};
		case (state_q)
			ST_IDLE: begin
				if (accept && (mode_q == MODE_TEXT)) begin
					push_valid = 1'b1;
					if (byte_in == 8'd0) begin
						push_item.kind = KIND_RESET;
					end
				end else if (accept && (mode_q == MODE_ONE_ZERO) && (byte_in != 8'd0)) begin
					push_valid = 1'b1;
				end
			end
			ST_EMPTY: begin
				push_valid = space;
				push_item = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1, stamp: stamp_q};
			end
			ST_E_BYTE: begin
				push_valid = space;
				push_item = '{kind: KIND_BYTE, data: rd_data, last: is_last, stamp: stamp_q};
			end
			ST_E_ZERO: begin
				push_valid = space;
				push_item = '{kind: KIND_BYTE, data: 8'd0, last: is_last, stamp: stamp_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_TEXT;
			fill_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			e_q <= '0;
			pos_q <= '0;
			end_q <= '0;
			code_q <= '0;
			stamp_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode_q)
							MODE_TEXT: begin
								if (byte_in == 8'd0) begin
									mode_q <= MODE_ONE_ZERO;
								end
							end
							MODE_ONE_ZERO: begin
								if (byte_in == 8'd0) begin
									fill_q <= '0;
									mode_q <= MODE_COLLECT;
								end else begin
									mode_q <= MODE_TEXT;
								end
							end
							MODE_COLLECT: begin
								if (byte_in == 8'd0) begin
									mode_q <= MODE_TEXT;
									stamp_q <= time_ms;
									idx_q <= '0;
									n_q <= '0;
									if (fill_q != '0) begin
										state_q <= ST_CHK_RD;
									end
								end else if (fill_q < CNT_W'(DEPTH)) begin
									fill_q <= fill_q + CNT_W'(1);
								end else begin
									mode_q <= MODE_DISCARD;
								end
							end
							default: begin
								if (byte_in == 8'd0) begin
									fill_q <= '0;
									mode_q <= MODE_TEXT;
								end
							end
						endcase
					end
				end
				ST_CHK_RD: begin
					if (idx_q < fill_q) begin
						state_q <= ST_CHK_EVAL;
					end else if (n_q == '0) begin
						state_q <= ST_EMPTY;
					end else begin
						idx_q <= '0;
						e_q <= '0;
						state_q <= ST_E_CODE_RD;
					end
				end
				ST_CHK_EVAL: begin
					if ((rd_data == 8'd0) || (alu_sum > SUM_W'(fill_q))) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= alu_sum[CNT_W-1:0];
						code_q <= rd_data;
						state_q <= ST_CHK_CNT;
					end
				end
				ST_CHK_CNT: begin
					n_q <= alu_sum[CNT_W-1:0];
					state_q <= ST_CHK_RD;
				end
				ST_EMPTY: begin
					if (space) begin
						state_q <= ST_DONE;
					end
				end
				ST_E_CODE_RD: begin
					state_q <= ST_E_CODE;
				end
				ST_E_CODE: begin
					code_q <= rd_data;
					end_q <= alu_sum[CNT_W-1:0];
					pos_q <= idx_q + CNT_W'(1);
					state_q <= ST_E_BYTE_RD;
				end
				ST_E_BYTE_RD: begin
					if (pos_q != end_q) begin
						state_q <= ST_E_BYTE;
					end else begin
						idx_q <= end_q;
						if ((code_q != 8'hFF) && (end_q < fill_q)) begin
							state_q <= ST_E_ZERO;
						end else if (end_q < fill_q) begin
							state_q <= ST_E_CODE_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_E_BYTE: begin
					if (space) begin
						pos_q <= pos_q + CNT_W'(1);
						e_q <= e_q + CNT_W'(1);
						state_q <= ST_E_BYTE_RD;
					end
				end
				ST_E_ZERO: begin
					if (space) begin
						e_q <= e_q + CNT_W'(1);
						state_q <= ST_E_CODE_RD;
					end
				end
				ST_DONE: begin
					fill_q <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	tcfd_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (byte_in),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	tcfd_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_valid   (push_valid),
		.push_item    (push_item),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.head         (head)
	);

	assign kind = head.kind;
	assign data = head.data;
	assign last_of_frame = head.last;
	assign frame_time = head.stamp;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count beyond store depth");

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> space)
		else $error("result pushed into a full queue");

	a_open_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode_q == MODE_ONE_ZERO) && (byte_in == 8'd0))
		|=> ((mode_q == MODE_COLLECT) && (fill_q == '0)))
		else $error("second zero did not open an empty frame");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && ((state_q == ST_E_BYTE) || (state_q == ST_E_ZERO))) |-> (e_q < n_q))
		else $error("more decoded bytes than counted");

endmodule
